@@ rtl/mpool_pkg.sv @@
// Shared codes, widths and types of the 2x2 max pooling block.
package mpool_pkg;

   // Request and result codes
   localparam logic REQ_FWD  = 1'b0;
   localparam logic REQ_BWD  = 1'b1;
   localparam logic KIND_FWD = 1'b0;
   localparam logic KIND_BWD = 1'b1;

   // Configuration register indexes and widths
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 7;
   localparam int CH_REG_BITS   = 5;
   localparam logic [CSR_IDX_BITS-1:0] CSR_IN_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_IN_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CHANNELS  = 2'd2;

   localparam logic [CSR_DATA_BITS-1:0] IN_WIDTH_RESET  = 7'd64;
   localparam logic [CSR_DATA_BITS-1:0] IN_HEIGHT_RESET = 7'd64;
   localparam logic [CH_REG_BITS-1:0]   CHANNELS_RESET  = 5'd16;

   // Flat index width on the result channel
   localparam int INDEX_BITS = 16;

   // Result queue
   localparam int QUEUE_DEPTH = 3;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   // Cycles for the geometry products to settle after a register write
   localparam int SETTLE_CYCLES = 2;
   localparam int SETTLE_BITS   = $clog2(SETTLE_CYCLES + 1);

   // Position of a sample in its window: row bit, column bit
   typedef logic [1:0] pos_type;

endpackage

@@ rtl/max_pool_2x2_with_argmax_top.sv @@
// Top level of the 2x2 stride-2 max pooling block with winner tracking.
//
// Forward words (req_type 0) stream samples in channel, row, column order; each completed
// 2x2 window yields its maximum (earlier sample wins a tie) and the flat input index of
// the winner, and the winner's window position is kept in an on-chip store of one entry
// per pooled output. Trailing odd rows and columns are dropped without a result.
// Backward words (req_type 1) carry pooled gradients in pooled order and come back with
// the flat input index of their stored winner; the consumer zeroes all other positions.
// rsp_last marks the final result of each tensor pass. Rate: one word per cycle while
// req_stall is low, forward and backward freely interleaved. The edge that takes a word
// also reads the running-max line memory (or the winner store); the next cycle compares
// and writes back, with the write forwarded to a back-to-back read of the same entry, and
// the result enters the queue at the end of that cycle. A three-word result queue lets
// input keep flowing while a result waits. A write to one of the three registers restarts
// both passes and holds req_stall while the geometry products (channels x pooled height x
// pooled width) settle; the same hold follows reset. Register values are clamped: width
// and height to 2..MAX_WIDTH / 2..MAX_HEIGHT, channels to 1..MAX_CHANNELS. The stores are
// not cleared: a backward word whose winner was never written returns an unspecified index.
module max_pool_2x2_with_argmax_top
   import mpool_pkg::*;
#(
   parameter int MAX_WIDTH    = 64,
   parameter int MAX_HEIGHT   = 64,
   parameter int MAX_CHANNELS = 16,
   parameter int VALUE_BITS   = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_type,
   input  logic signed [VALUE_BITS-1:0] req_value,
   // result channel
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_kind,
   output logic signed [VALUE_BITS-1:0] rsp_value_res,
   output logic [INDEX_BITS-1:0]       rsp_index,
   output logic                        rsp_last,
   // configuration write channel
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [CSR_IDX_BITS-1:0]     csr_index,
   input  logic [CSR_DATA_BITS-1:0]    csr_wdata
);

   // ---------------------------------------------------------------- sizes
   localparam int LINE_DEPTH  = MAX_WIDTH / 2;
   localparam int LINE_AW     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
   localparam int STORE_DEPTH = MAX_CHANNELS * (MAX_HEIGHT / 2) * (MAX_WIDTH / 2);
   localparam int STORE_AW    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int TOT_BITS    = $clog2(STORE_DEPTH + 1);
   localparam int W_BITS      = $clog2(MAX_WIDTH + 1);
   localparam int H_BITS      = $clog2(MAX_HEIGHT + 1);
   localparam int CH_BITS     = $clog2(MAX_CHANNELS + 1);
   localparam int X_BITS      = $clog2(MAX_WIDTH);
   localparam int R_BITS      = $clog2(MAX_HEIGHT);
   localparam int C_BITS      = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int OW_BITS     = $clog2(MAX_WIDTH / 2 + 1);
   localparam int OH_BITS     = $clog2(MAX_HEIGHT / 2 + 1);
   localparam int PH_BITS     = (MAX_HEIGHT / 2 > 1) ? $clog2(MAX_HEIGHT / 2) : 1;
   localparam int PROD_BITS   = $clog2(MAX_CHANNELS * (MAX_HEIGHT / 2) + 1);
   localparam int LINE_BITS   = 2 + VALUE_BITS;
   localparam int WORD_BITS   = 1 + VALUE_BITS + INDEX_BITS + 1;

   // ---------------------------------------------------------------- configuration
   logic [CSR_DATA_BITS-1:0] in_width_ff, in_height_ff;
   logic [CH_REG_BITS-1:0]   channels_ff;
   logic                     csr_write;
   logic                     csr_hit;
   logic [SETTLE_BITS-1:0]   settle_ff;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign csr_hit   = csr_write && (csr_index == CSR_IN_WIDTH || csr_index == CSR_IN_HEIGHT ||
                                    csr_index == CSR_CHANNELS);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_width_ff  <= IN_WIDTH_RESET;
         in_height_ff <= IN_HEIGHT_RESET;
         channels_ff  <= CHANNELS_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_IN_WIDTH:  in_width_ff  <= csr_wdata;
            CSR_IN_HEIGHT: in_height_ff <= csr_wdata;
            CSR_CHANNELS:  channels_ff  <= csr_wdata[CH_REG_BITS-1:0];
            default:       ; // unlisted index: drop the word
         endcase
      end
   end

   // Hold input after reset or a register write until the products are valid.
   always_ff @(posedge clock) begin
      if (reset || csr_hit) begin
         settle_ff <= SETTLE_BITS'(SETTLE_CYCLES);
      end else if (settle_ff != '0) begin
         settle_ff <= settle_ff - 1'b1;
      end
   end

   // ---------------------------------------------------------------- clamped geometry
   logic [W_BITS-1:0]     w, w_even;
   logic [H_BITS-1:0]     h, h_even;
   logic [CH_BITS-1:0]    ch;
   logic [OW_BITS-1:0]    ow;
   logic [OH_BITS-1:0]    oh;
   logic [PROD_BITS-1:0]  prod_ff;
   logic [TOT_BITS-1:0]   total_ff;
   logic [INDEX_BITS-1:0] hw_ff;
   logic [INDEX_BITS-1:0] w_ix;

   always_comb begin
      if (int'(in_width_ff) < 2)               w = W_BITS'(2);
      else if (int'(in_width_ff) > MAX_WIDTH)  w = W_BITS'(MAX_WIDTH);
      else                                     w = W_BITS'(in_width_ff);
      if (int'(in_height_ff) < 2)              h = H_BITS'(2);
      else if (int'(in_height_ff) > MAX_HEIGHT) h = H_BITS'(MAX_HEIGHT);
      else                                     h = H_BITS'(in_height_ff);
      if (int'(channels_ff) < 1)               ch = CH_BITS'(1);
      else if (int'(channels_ff) > MAX_CHANNELS) ch = CH_BITS'(MAX_CHANNELS);
      else                                     ch = CH_BITS'(channels_ff);
   end

   assign w_even = {w[W_BITS-1:1], 1'b0};
   assign h_even = {h[H_BITS-1:1], 1'b0};
   assign ow     = OW_BITS'(w >> 1);
   assign oh     = OH_BITS'(h >> 1);
   assign w_ix   = INDEX_BITS'(w);

   // Registered products: channels x pooled height, then x pooled width; height x width beside the first.
   always_ff @(posedge clock) begin
      prod_ff  <= PROD_BITS'(PROD_BITS'(ch) * PROD_BITS'(oh));
      total_ff <= TOT_BITS'(TOT_BITS'(prod_ff) * TOT_BITS'(ow));
      hw_ff    <= INDEX_BITS'(INDEX_BITS'(h) * w_ix);
   end

   // ---------------------------------------------------------------- request side
   logic fire, fire_fwd, fire_bwd;
   logic [QCNT_BITS-1:0] q_count;
   logic                 s1_valid_ff;

   assign req_stall = (settle_ff != '0) ||
                      ((QCNT_BITS + 1)'(q_count) + (QCNT_BITS + 1)'(s1_valid_ff)
                       >= (QCNT_BITS + 1)'(QUEUE_DEPTH));
   assign fire     = req_valid && !req_stall;
   assign fire_fwd = fire && (req_type == REQ_FWD);
   assign fire_bwd = fire && (req_type == REQ_BWD);

   // Forward position counters
   logic [C_BITS-1:0]     fwd_c_ff;
   logic [R_BITS-1:0]     fwd_r_ff;
   logic [X_BITS-1:0]     fwd_x_ff;
   logic [INDEX_BITS-1:0] fwd_flat_ff;    // flat index of the next sample
   logic [STORE_AW-1:0]   fwd_pidx_ff;    // pooled index of the next window to close
   logic                  fwd_live;
   pos_type               fwd_pos;
   logic                  fwd_close;
   logic                  fwd_pass_last;
   logic                  row_end, plane_end, pass_end;
   logic [LINE_AW-1:0]    fwd_pw;

   assign fwd_live  = (H_BITS'(fwd_r_ff) < h_even) && (W_BITS'(fwd_x_ff) < w_even);
   assign fwd_pos   = {fwd_r_ff[0], fwd_x_ff[0]};
   assign fwd_close = fwd_live && (fwd_pos == 2'b11);
   assign fwd_pw    = LINE_AW'(fwd_x_ff >> 1);
   assign fwd_pass_last = (TOT_BITS'(fwd_pidx_ff) + TOT_BITS'(1)) == total_ff;
   assign row_end   = (W_BITS'(fwd_x_ff) + W_BITS'(1)) == w;
   assign plane_end = row_end && ((H_BITS'(fwd_r_ff) + H_BITS'(1)) == h);
   assign pass_end  = plane_end && ((CH_BITS'(fwd_c_ff) + CH_BITS'(1)) == ch);

   always_ff @(posedge clock) begin
      if (reset || csr_hit) begin
         fwd_c_ff    <= '0;
         fwd_r_ff    <= '0;
         fwd_x_ff    <= '0;
         fwd_flat_ff <= '0;
         fwd_pidx_ff <= '0;
      end else if (fire_fwd) begin
         fwd_x_ff    <= row_end ? '0 : fwd_x_ff + 1'b1;
         fwd_flat_ff <= pass_end ? '0 : fwd_flat_ff + 1'b1;
         if (row_end) begin
            fwd_r_ff <= plane_end ? '0 : fwd_r_ff + 1'b1;
         end
         if (plane_end) begin
            fwd_c_ff <= pass_end ? '0 : fwd_c_ff + 1'b1;
         end
         priority if (pass_end || (fwd_close && fwd_pass_last)) begin
            fwd_pidx_ff <= '0;
         end else if (fwd_close) begin
            fwd_pidx_ff <= fwd_pidx_ff + 1'b1;
         end else begin
            fwd_pidx_ff <= fwd_pidx_ff;
         end
      end
   end

   // Backward position counters
   logic [STORE_AW-1:0]   bwd_p_ff;
   logic [PH_BITS-1:0]    bwd_ph_ff;
   logic [LINE_AW-1:0]    bwd_pw_ff;
   logic [INDEX_BITS-1:0] bwd_base_ff;   // flat index of the window's top-left sample
   logic [INDEX_BITS-1:0] bwd_row_ff;    // flat index of the pooled row's first sample
   logic [INDEX_BITS-1:0] bwd_chan_ff;   // flat index of the channel's first sample
   logic                  bwd_last;
   logic                  bwd_row_end, bwd_plane_end;
   logic [INDEX_BITS-1:0] next_row, next_chan;

   assign bwd_last      = (TOT_BITS'(bwd_p_ff) + TOT_BITS'(1)) == total_ff;
   assign bwd_row_end   = (OW_BITS'(bwd_pw_ff) + OW_BITS'(1)) == ow;
   assign bwd_plane_end = bwd_row_end && ((OH_BITS'(bwd_ph_ff) + OH_BITS'(1)) == oh);
   assign next_row      = bwd_row_ff + {w_ix[INDEX_BITS-2:0], 1'b0};
   assign next_chan     = bwd_chan_ff + hw_ff;

   always_ff @(posedge clock) begin
      if (reset || csr_hit) begin
         bwd_p_ff    <= '0;
         bwd_ph_ff   <= '0;
         bwd_pw_ff   <= '0;
         bwd_base_ff <= '0;
         bwd_row_ff  <= '0;
         bwd_chan_ff <= '0;
      end else if (fire_bwd) begin
         priority if (bwd_last) begin
            bwd_p_ff    <= '0;
            bwd_ph_ff   <= '0;
            bwd_pw_ff   <= '0;
            bwd_base_ff <= '0;
            bwd_row_ff  <= '0;
            bwd_chan_ff <= '0;
         end else if (bwd_plane_end) begin
            bwd_p_ff    <= bwd_p_ff + 1'b1;
            bwd_ph_ff   <= '0;
            bwd_pw_ff   <= '0;
            bwd_base_ff <= next_chan;
            bwd_row_ff  <= next_chan;
            bwd_chan_ff <= next_chan;
         end else if (bwd_row_end) begin
            bwd_p_ff    <= bwd_p_ff + 1'b1;
            bwd_ph_ff   <= bwd_ph_ff + 1'b1;
            bwd_pw_ff   <= '0;
            bwd_base_ff <= next_row;
            bwd_row_ff  <= next_row;
         end else begin
            bwd_p_ff    <= bwd_p_ff + 1'b1;
            bwd_pw_ff   <= bwd_pw_ff + 1'b1;
            bwd_base_ff <= bwd_base_ff + INDEX_BITS'(2);
         end
      end
   end

   // ---------------------------------------------------------------- memories
   // Running best per pooled column: {position, value}
   logic [LINE_BITS-1:0] line_mem [LINE_DEPTH];
   logic [LINE_BITS-1:0] line_rd_ff;
   logic                 line_we;
   logic [LINE_AW-1:0]   line_wa;
   logic [LINE_BITS-1:0] line_wd;

   // Winner position per pooled output
   pos_type              store_mem [STORE_DEPTH];
   pos_type              store_rd_ff;
   logic                 store_we;
   logic [STORE_AW-1:0]  store_wa;
   pos_type              store_wd;

   always_ff @(posedge clock) begin
      if (fire_fwd) begin
         line_rd_ff <= line_mem[fwd_pw];
      end
      if (line_we) begin
         line_mem[line_wa] <= line_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (fire_bwd) begin
         store_rd_ff <= store_mem[bwd_p_ff];
      end
      if (store_we) begin
         store_mem[store_wa] <= store_wd;
      end
   end

   // Last cycle's writes, to cover a read issued in the same cycle
   logic                 line_fwd_valid_ff;
   logic [LINE_AW-1:0]   line_fwd_addr_ff;
   logic [LINE_BITS-1:0] line_fwd_data_ff;
   logic                 store_fwd_valid_ff;
   logic [STORE_AW-1:0]  store_fwd_addr_ff;
   pos_type              store_fwd_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_fwd_valid_ff  <= 1'b0;
         store_fwd_valid_ff <= 1'b0;
      end else begin
         line_fwd_valid_ff  <= line_we;
         store_fwd_valid_ff <= store_we;
      end
   end

   always_ff @(posedge clock) begin
      line_fwd_addr_ff  <= line_wa;
      line_fwd_data_ff  <= line_wd;
      store_fwd_addr_ff <= store_wa;
      store_fwd_data_ff <= store_wd;
   end

   // ---------------------------------------------------------------- compare stage
   logic                         s1_bwd_ff;
   logic                         s1_live_ff;
   pos_type                      s1_pos_ff;
   logic [LINE_AW-1:0]           s1_pw_ff;
   logic signed [VALUE_BITS-1:0] s1_value_ff;
   logic [INDEX_BITS-1:0]        s1_flat_ff;   // forward: sample index; backward: window base
   logic [STORE_AW-1:0]          s1_addr_ff;   // winner store entry
   logic                         s1_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= fire;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         s1_bwd_ff   <= (req_type == REQ_BWD);
         s1_live_ff  <= fwd_live;
         s1_pos_ff   <= fwd_pos;
         s1_pw_ff    <= fwd_pw;
         s1_value_ff <= req_value;
         s1_flat_ff  <= (req_type == REQ_BWD) ? bwd_base_ff : fwd_flat_ff;
         s1_addr_ff  <= (req_type == REQ_BWD) ? bwd_p_ff : fwd_pidx_ff;
         s1_last_ff  <= (req_type == REQ_BWD) ? bwd_last : fwd_pass_last;
      end
   end

   logic [LINE_BITS-1:0]         line_old;
   logic signed [VALUE_BITS-1:0] old_value;
   logic signed [VALUE_BITS-1:0] best_value;
   pos_type                      best_pos;
   pos_type                      bwd_win;
   logic                         s1_fwd_active;
   logic                         s1_produce;
   logic [INDEX_BITS-1:0]        fwd_index, bwd_index;
   logic [INDEX_BITS-1:0]        res_index;
   logic signed [VALUE_BITS-1:0] res_value;

   assign line_old  = (line_fwd_valid_ff && line_fwd_addr_ff == s1_pw_ff) ?
                      line_fwd_data_ff : line_rd_ff;
   assign old_value = line_old[VALUE_BITS-1:0];

   always_comb begin
      // The first sample of a window opens it; later ones replace only if larger.
      if (s1_pos_ff == 2'b00 || s1_value_ff > old_value) begin
         best_value = s1_value_ff;
         best_pos   = s1_pos_ff;
      end else begin
         best_value = old_value;
         best_pos   = line_old[LINE_BITS-1:VALUE_BITS];
      end
   end

   assign s1_fwd_active = s1_valid_ff && !s1_bwd_ff && s1_live_ff;
   assign line_we  = s1_fwd_active;
   assign line_wa  = s1_pw_ff;
   assign line_wd  = {best_pos, best_value};
   assign store_we = s1_fwd_active && (s1_pos_ff == 2'b11);
   assign store_wa = s1_addr_ff;
   assign store_wd = best_pos;

   assign bwd_win = (store_fwd_valid_ff && store_fwd_addr_ff == s1_addr_ff) ?
                    store_fwd_data_ff : store_rd_ff;

   // Step back from the bottom-right sample to the winner.
   assign fwd_index = s1_flat_ff - (best_pos[1] ? '0 : w_ix)
                                 - (best_pos[0] ? '0 : INDEX_BITS'(1));
   assign bwd_index = s1_flat_ff + (bwd_win[1] ? w_ix : '0)
                                 + (bwd_win[0] ? INDEX_BITS'(1) : '0);

   assign s1_produce = s1_valid_ff && (s1_bwd_ff || (s1_live_ff && s1_pos_ff == 2'b11));
   assign res_index  = s1_bwd_ff ? bwd_index : fwd_index;
   assign res_value  = s1_bwd_ff ? s1_value_ff : best_value;

   // ---------------------------------------------------------------- result queue
   logic [WORD_BITS-1:0] push_word, out_word;

   assign push_word = {(s1_bwd_ff ? KIND_BWD : KIND_FWD), res_value, res_index, s1_last_ff};

   mpool_rsp_queue #(
      .WORD_BITS (WORD_BITS)
   ) u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (s1_produce),
      .push_word  (push_word),
      .out_stall  (rsp_stall),
      .out_valid  (rsp_valid),
      .out_word   (out_word),
      .count      (q_count)
   );

   assign rsp_kind      = out_word[WORD_BITS-1];
   assign rsp_value_res = out_word[WORD_BITS-2 -: VALUE_BITS];
   assign rsp_index     = out_word[INDEX_BITS:1];
   assign rsp_last      = out_word[0];

   // ---------------------------------------------------------------- checks
   a_queue_room: assert property (@(posedge clock) disable iff (reset)
      ((QCNT_BITS + 1)'(q_count) + (QCNT_BITS + 1)'(s1_valid_ff))
         <= (QCNT_BITS + 1)'(QUEUE_DEPTH))
      else $error("result queue could overflow");

   a_close_emits: assert property (@(posedge clock) disable iff (reset)
      (fire_fwd && fwd_close) |=> (s1_produce && store_we))
      else $error("closed window gave no result");

   a_settle_after_write: assert property (@(posedge clock) disable iff (reset)
      csr_hit |=> req_stall ##1 req_stall)
      else $error("input taken before geometry settled");

   a_bwd_in_pass: assert property (@(posedge clock) disable iff (reset)
      (settle_ff == '0) |-> (TOT_BITS'(bwd_p_ff) < total_ff))
      else $error("backward position beyond pass");

endmodule

@@ rtl/mpool_rsp_queue.sv @@
// Small result queue that parts the pooling pipeline from the result channel.
module mpool_rsp_queue
   import mpool_pkg::*;
#(
   parameter int WORD_BITS = 34
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   input  logic [WORD_BITS-1:0] push_word,
   input  logic                 out_stall,
   output logic                 out_valid,
   output logic [WORD_BITS-1:0] out_word,
   output logic [QCNT_BITS-1:0] count
);

   logic [WORD_BITS-1:0] entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] head_ff, head_in;
   logic [QPTR_BITS-1:0] tail_ff, tail_in;
   logic [QCNT_BITS-1:0] count_ff, count_in;
   logic                 pop;

   assign out_valid = (count_ff != '0);
   assign out_word  = entry_ff[head_ff];
   assign count     = count_ff;
   assign pop       = out_valid && !out_stall;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (pop) begin
         head_in = (head_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
      end
      if (push_valid) begin
         tail_in = (tail_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + 1'b1;
      end
      unique case ({push_valid, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entry_ff[tail_ff] <= push_word;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (count_ff == QCNT_BITS'(QUEUE_DEPTH)) |-> !push_valid || pop)
      else $error("result queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |=> (count_ff <= QCNT_BITS'(1)))
      else $error("result queue count jumped from empty");

   a_order: assert property (@(posedge clock) disable iff (reset)
      (out_valid && out_stall && !push_valid) |=> $stable(count_ff))
      else $error("result queue count moved while stalled");

endmodule

@@ tb/sv/tb_max_pool_2x2_with_argmax_top.sv @@
// Self-checking bench for the 2x2 max pooling block: directed and random words vs a local predictor.
module tb_max_pool_2x2_with_argmax_top
   import mpool_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_W        = 64;
   localparam int MAX_H        = 64;
   localparam int MAX_CH       = 16;
   localparam int STORE_DEPTH  = MAX_CH * (MAX_H / 2) * (MAX_W / 2);
   localparam int TOTAL_WORDS  = 800;
   localparam int DRAIN_CYCLES = 6;
   localparam int IDLE_LIMIT   = 2000;
   localparam int REPORT_CAP   = 40;

   // index with no register behind it: a write there changes nothing
   localparam logic [CSR_IDX_BITS-1:0] CSR_UNUSED = 2'd3;

   // window positions: top left opens a window, bottom right closes it
   localparam pos_type POS_FIRST = 2'd0;
   localparam pos_type POS_LAST  = 2'd3;

   typedef enum int {STALL_NONE, STALL_PATTERN, STALL_STRETCH, STALL_RANDOM} stall_mode_type;

   typedef struct packed {
      logic               kind;
      logic signed [15:0] value;
      logic [15:0]        index;
      logic               last;
   } pool_result_type;

   typedef struct packed {
      logic               rtype;
      logic signed [15:0] value;
      bit                 yields;
      pool_result_type    due;
   } pool_word_type;

   logic                            clock         = 1'b0;
   logic                            reset         = 1'b1;
   logic                            req_valid     = 1'b0;
   logic                            req_stall;
   logic                            req_type      = REQ_FWD;
   logic signed [15:0]              req_value     = '0;
   logic                            rsp_valid;
   logic                            rsp_stall     = 1'b0;
   logic                            rsp_kind;
   logic signed [15:0]              rsp_value_res;
   logic [INDEX_BITS-1:0]           rsp_index;
   logic                            rsp_last;
   logic                            csr_valid     = 1'b0;
   logic                            csr_ready;
   logic [CSR_IDX_BITS-1:0]         csr_index     = CSR_IN_WIDTH;
   logic [CSR_DATA_BITS-1:0]        csr_wdata     = '0;

   max_pool_2x2_with_argmax_top dut (.*);

   always #4 clock = ~clock;

   // ---------------------------------------------------------------------------------------
   // Predictor state: register copies, running-max line, winner store and the two counters
   // ---------------------------------------------------------------------------------------
   logic [CSR_DATA_BITS-1:0] cfg_width    = IN_WIDTH_RESET;
   logic [CSR_DATA_BITS-1:0] cfg_height   = IN_HEIGHT_RESET;
   logic [CH_REG_BITS-1:0]   cfg_channels = CHANNELS_RESET;
   logic signed [15:0]       line_max [MAX_W / 2];
   pos_type                  line_pos [MAX_W / 2];
   pos_type                  choice_store [STORE_DEPTH];
   bit                       choice_written [STORE_DEPTH];
   int                       fwd_ch  = 0;
   int                       fwd_row = 0;
   int                       fwd_col = 0;
   int                       bwd_pos = 0;

   pool_word_type   sample_queue [$];
   pool_result_type results_due [$];
   int              words_planned = 0;
   int              results_seen  = 0;
   int              mismatches    = 0;
   int              idle_cycles   = 0;

   // Clamp the register copies to the geometry the block really uses.
   function automatic void geometry(output int w, output int h, output int ch);
      w  = int'(cfg_width);
      h  = int'(cfg_height);
      ch = int'(cfg_channels);
      if (w < 2) w = 2; else if (w > MAX_W) w = MAX_W;
      if (h < 2) h = 2; else if (h > MAX_H) h = MAX_H;
      if (ch < 1) ch = 1; else if (ch > MAX_CH) ch = MAX_CH;
   endfunction

   function automatic logic [15:0] flat_index(input int c, input int row, input int col,
                                              input int w, input int h);
      return 16'((c * h + row) * w + col);
   endfunction

   // Advance the predictor by one request word; returns 1 when the word yields a result.
   function automatic bit pool_predict(input logic rtype, input logic signed [15:0] v,
                                       output pool_result_type r);
      int      w, h, ch, ow, oh, total, pw, ph, pidx, p;
      pos_type pos, win;
      bit      yields;
      geometry(w, h, ch);
      ow     = w / 2;
      oh     = h / 2;
      total  = ch * oh * ow;
      yields = 1'b0;
      r      = '0;
      if (rtype == REQ_FWD) begin
         // samples in a trailing odd row or column only move the counters
         if (fwd_ch < ch && fwd_row < 2 * oh && fwd_col < 2 * ow) begin
            pw  = fwd_col / 2;
            pos = {fwd_row[0], fwd_col[0]};
            // a later sample takes over only on a strict gain, so ties keep the earlier one
            if (pos == POS_FIRST || v > line_max[pw]) begin
               line_max[pw] = v;
               line_pos[pw] = pos;
            end
            if (pos == POS_LAST) begin
               ph   = fwd_row / 2;
               pidx = fwd_ch * oh * ow + ph * ow + pw;
               win  = line_pos[pw];
               choice_store[pidx]   = win;
               choice_written[pidx] = 1'b1;
               r.kind  = KIND_FWD;
               r.value = line_max[pw];
               r.index = flat_index(fwd_ch, 2 * ph + win[1], 2 * pw + win[0], w, h);
               r.last  = (pidx + 1 == total);
               yields  = 1'b1;
            end
         end
         fwd_col++;
         if (fwd_col >= w) begin
            fwd_col = 0;
            fwd_row++;
            if (fwd_row >= h) begin
               fwd_row = 0;
               fwd_ch++;
               if (fwd_ch >= ch) fwd_ch = 0;
            end
         end
      end else begin
         p   = (bwd_pos >= total) ? 0 : bwd_pos;
         win = choice_store[p];
         ph  = (p % (oh * ow)) / ow;
         pw  = p % ow;
         r.kind  = KIND_BWD;
         r.value = v;
         r.index = flat_index(p / (oh * ow), 2 * ph + win[1], 2 * pw + win[0], w, h);
         r.last  = (p + 1 == total);
         yields  = 1'b1;
         bwd_pos = (p + 1 >= total) ? 0 : p + 1;
      end
      return yields;
   endfunction

   // A gradient may go out only when its window winner has been written by some forward pass.
   function automatic bit bwd_legal();
      int w, h, ch;
      geometry(w, h, ch);
      return choice_written[(bwd_pos >= ch * (h / 2) * (w / 2)) ? 0 : bwd_pos];
   endfunction

   function automatic void plan_word(input logic rtype, input logic signed [15:0] v);
      pool_word_type wd;
      wd.rtype  = rtype;
      wd.value  = v;
      wd.yields = pool_predict(rtype, v, wd.due);
      sample_queue.insert(sample_queue.size(), wd);
      words_planned++;
   endfunction

   // Lean on small values so ties inside a window are frequent.
   function automatic logic signed [15:0] pick_value();
      case ($urandom_range(0, 7))
         0:       return 16'sh7FFF;
         1:       return 16'sh8000;
         2, 3:    return 16'($urandom);
         default: return 16'(int'($urandom_range(0, 6)) - 3);
      endcase
   endfunction

   // Interleave forward samples with legal gradients; forward counts run whole passes mostly.
   function automatic void run_phase(input int fwd_left, input int bwd_left);
      while (fwd_left > 0 || (bwd_left > 0 && bwd_legal())) begin
         if (bwd_left > 0 && bwd_legal() && (fwd_left == 0 || $urandom_range(0, 3) == 0)) begin
            plan_word(REQ_BWD, pick_value());
            bwd_left--;
         end else begin
            plan_word(REQ_FWD, pick_value());
            fwd_left--;
         end
      end
   endfunction

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      if (mismatches < REPORT_CAP)
         $display("mismatch at result %0d: %s got %h want %h", results_seen, what, got, want);
      mismatches++;
   endtask

   // Hold until every queued word is taken and every result is back, then let the pipe empty.
   task automatic wait_drain();
      while (sample_queue.size() != 0 || req_valid || results_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      // mirror the write; any real register restarts both passes
      case (idx)
         CSR_IN_WIDTH:  cfg_width    = data;
         CSR_IN_HEIGHT: cfg_height   = data;
         CSR_CHANNELS:  cfg_channels = data[CH_REG_BITS-1:0];
         default:       return;
      endcase
      fwd_ch  = 0;
      fwd_row = 0;
      fwd_col = 0;
      bwd_pos = 0;
   endtask

   // Pick a geometry: mostly small maps, sometimes the extremes and out-of-range values.
   task automatic new_geometry();
      logic [CSR_DATA_BITS-1:0] w, h, c;
      int                       first;
      if ($urandom_range(0, 3) != 0) begin
         w = 7'($urandom_range(2, 9));
         h = 7'($urandom_range(2, 9));
         c = 7'($urandom_range(1, 3));
      end else begin
         case ($urandom_range(0, 3))
            0: begin
               w = 7'($urandom_range(64, 127));
               h = 7'($urandom_range(0, 3));
               c = 7'($urandom_range(0, 1));
            end
            1: begin
               w = 7'($urandom_range(0, 3));
               h = 7'($urandom_range(64, 127));
               c = 7'($urandom_range(0, 1));
            end
            2: begin
               w = 7'($urandom_range(0, 2));
               h = 7'($urandom_range(0, 2));
               c = 7'($urandom_range(16, 127));
            end
            default: begin
               w = 7'($urandom_range(10, 40));
               h = 7'($urandom_range(2, 5));
               c = 7'($urandom);
            end
         endcase
      end
      first = $urandom_range(0, 2);
      for (int k = 0; k < 3; k++) begin
         case ((first + k) % 3)
            0:       write_reg(CSR_IN_WIDTH, w);
            1:       write_reg(CSR_IN_HEIGHT, h);
            default: write_reg(CSR_CHANNELS, c);
         endcase
      end
      if ($urandom_range(0, 5) == 0) write_reg(CSR_UNUSED, 7'($urandom));
   endtask

   // ---------------------------------------------------------------------------------------
   // Request driver: bursts of random length with random gaps, fed from sample_queue.
   // The word on the wire stays put until taken; its results fall due at the taking edge.
   // ---------------------------------------------------------------------------------------
   pool_word_type on_wire;
   int            burst_left = 0;
   int            gap_left   = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall && on_wire.yields)
            results_due.insert(results_due.size(), on_wire.due);
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (sample_queue.size() > 0) begin
               on_wire = sample_queue.pop_front();
               req_valid <= 1'b1;
               req_type  <= on_wire.rtype;
               req_value <= on_wire.value;
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  // close the burst; a third of bursts run straight into the next one
                  burst_left = $urandom_range(1, 24);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Result stall: a mode drawn at random - none, a 16-bit pattern, a recurring stretch or a stall
   // one time in four - so stalls land on every phase of the pipeline, with quiet stretches too.
   // ---------------------------------------------------------------------------------------
   int             stall_tick = 0;
   logic [15:0]    stall_mask = '0;
   stall_mode_type stall_mode = STALL_NONE;

   always @(posedge clock) begin
      if (stall_tick % 64 == 0) begin
         stall_mask = 16'($urandom);
         stall_mode = stall_mode_type'($urandom_range(0, 3));
      end
      case (stall_mode)
         STALL_NONE:    rsp_stall <= 1'b0;
         STALL_PATTERN: rsp_stall <= stall_mask[stall_tick % 16];
         STALL_STRETCH: rsp_stall <= ((stall_tick / 8) % 4 == 1);
         default:       rsp_stall <= ($urandom_range(0, 3) == 0);
      endcase
      stall_tick++;
   end

   // ---------------------------------------------------------------------------------------
   // Result check: every taken result word against the oldest one due, field by field.
   // ---------------------------------------------------------------------------------------
   always @(posedge clock) begin
      pool_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (results_due.size() == 0) begin
            report_mismatch("result with nothing due, index", rsp_index, '0);
         end else begin
            want = results_due.pop_front();
            if (rsp_kind !== want.kind)       report_mismatch("kind", 16'(rsp_kind), 16'(want.kind));
            if (rsp_value_res !== want.value) report_mismatch("value", rsp_value_res, want.value);
            if (rsp_index !== want.index)     report_mismatch("index", rsp_index, want.index);
            if (rsp_last !== want.last)       report_mismatch("last", 16'(rsp_last), 16'(want.last));
         end
         results_seen++;
      end
   end

   // Watchdog: too long without any word moving on any channel ends the run.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Stimulus sequence
   // ---------------------------------------------------------------------------------------
   initial begin
      int w, h, ch, pass_len, bwd_n, fwd_n;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Reset geometry (64 x 64 x 16): two full rows close the first line of windows.
      run_phase(130, 24);
      wait_drain();

      // Directed: 2 x 2 x 2, whole-window tie, tie between the two lower samples,
      // winners in the last and the second slot, value extremes, pass wrap both ways.
      write_reg(CSR_IN_WIDTH, 7'd2);
      write_reg(CSR_IN_HEIGHT, 7'd2);
      write_reg(CSR_CHANNELS, 7'd2);
      plan_word(REQ_FWD, 16'sd5);
      plan_word(REQ_FWD, 16'sd5);
      plan_word(REQ_FWD, 16'sd5);
      plan_word(REQ_FWD, 16'sd5);
      plan_word(REQ_FWD, 16'sh8000);
      plan_word(REQ_FWD, 16'sh8000);
      plan_word(REQ_FWD, 16'sh7FFF);
      plan_word(REQ_FWD, 16'sh7FFF);
      plan_word(REQ_BWD, 16'sh7FFF);
      plan_word(REQ_BWD, 16'sh8000);
      plan_word(REQ_FWD, -16'sd1);
      plan_word(REQ_FWD, -16'sd2);
      plan_word(REQ_FWD, 16'sd0);
      plan_word(REQ_FWD, 16'sd1);
      plan_word(REQ_FWD, 16'sd0);
      plan_word(REQ_FWD, 16'sd7);
      plan_word(REQ_FWD, 16'sd7);
      plan_word(REQ_FWD, -16'sd7);
      plan_word(REQ_BWD, 16'sh5555);
      plan_word(REQ_BWD, 16'shAAAA);
      wait_drain();

      // Directed: 3 x 3 with channels written as zero; the largest samples sit in the
      // dropped column and row and must not win. The unused index leaves counters alone.
      write_reg(CSR_UNUSED, 7'h7F);
      write_reg(CSR_IN_WIDTH, 7'd3);
      write_reg(CSR_IN_HEIGHT, 7'd3);
      write_reg(CSR_CHANNELS, 7'd0);
      plan_word(REQ_FWD, 16'sh0100);
      plan_word(REQ_FWD, 16'sh0080);
      plan_word(REQ_FWD, 16'sh7FFF);
      plan_word(REQ_FWD, 16'sh0180);
      plan_word(REQ_FWD, 16'sh0100);
      plan_word(REQ_FWD, 16'sh7FFF);
      for (int k = 0; k < 3; k++) plan_word(REQ_FWD, 16'sh7FFF);
      plan_word(REQ_BWD, 16'sh0042);

      // Random: geometry phases of mostly whole passes; some phases keep the geometry
      // and carry on mid-pass, a register write mid-pass breaks a sequence. The forward
      // share of a phase stops at the overall word budget.
      while (words_planned < TOTAL_WORDS) begin
         if ($urandom_range(0, 4) != 0) begin
            wait_drain();
            new_geometry();
         end
         geometry(w, h, ch);
         pass_len = w * h * ch;
         bwd_n    = $urandom_range(0, ch * (h / 2) * (w / 2) + 4);
         if (bwd_n > 120) bwd_n = 120;
         fwd_n    = (pass_len <= 200) ? pass_len + $urandom_range(0, pass_len)
                                      : $urandom_range(60, 200);
         if (fwd_n > TOTAL_WORDS - words_planned) fwd_n = TOTAL_WORDS - words_planned;
         run_phase(fwd_n, bwd_n);
      end
      wait_drain();

      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
